// ===== rtl/pll_divider_search_assert.svh =====
// Assertion macros shared by the PLL divider search modules.
// Depends on nothing; included by the controller and the top level.
`ifndef PLL_DIVIDER_SEARCH_ASSERT_SVH
`define PLL_DIVIDER_SEARCH_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define PDS_ASSERT_IMP(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("pll divider search check failed");

// Implication checked in the cycle after the condition.
`define PDS_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("pll divider search check failed");

`endif

// ===== rtl/pds_pkg.sv =====
// Package for the PLL divider search: widths, codes and controller interface types.
// Depends on nothing; imported by every module of the block.
package pds_pkg;

  localparam int M_MAX = 127;
  localparam int N_MAX = 31;
  localparam int R_MAX = 3;

  localparam logic [23:0] ERR_FIELD_MAX = 24'hFFFFFF;
  localparam logic [19:0] KHZ_FIELD_MAX = 20'hFFFFF;
  localparam logic [19:0] PPM_SCALE = 20'd1000000;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_REF_CLOCK = 2'd0;
  localparam logic [1:0] REG_VCO_MIN   = 2'd1;
  localparam logic [1:0] REG_VCO_MAX   = 2'd2;
  localparam logic [1:0] REG_MAX_ERROR = 2'd3;

  // Status codes of a result.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  // Divider quotient widths: ppm quotient may need 42 bits, achieved up to 24.
  localparam int PPM_NUM_W = 64;
  localparam int PPM_DEN_W = 32;
  localparam int DIV_STEPS = PPM_NUM_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_PPM,
    S_KHZ,
    S_DONE
  } pds_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;        // capture target, reset search counters
    logic search;      // evaluate one candidate and advance counters
    logic ppm_start;   // start the error division
    logic khz_start;   // start the frequency division
    logic finish;      // form the result into the output register
  } pds_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic search_last; // current candidate is the last combination
    logic div_busy;    // divider still iterating
    logic div_done;    // divider finished this cycle
  } pds_stat_t;

endpackage

// ===== rtl/pll_divider_search.sv =====
// Top level of the PLL divider search: configuration registers, output register.
// Depends on pds_pkg, pds_control, pds_datapath and the assertion header.
//
// Use: a target in kHz is offered on target_freq with in_valid; it is taken
// when in_valid is high and in_stall low. One result transfer follows per item
// on out_valid/out_stall with the dividers, packed bytes, frequency and error.
// The search tries one M,N,R candidate per cycle, then the error division and
// the frequency division run on the shared serial divider, and the output is
// loaded last. A zero target skips the search and both divisions. One item is
// in work at a time: the next item is taken only when the controller is idle
// and the output register is empty or being transferred in that cycle; until
// then in_stall stays high. Reset restores the configuration defaults and
// empties the block. A stalled receiver holds the result steady and stops new
// items from being taken. Configuration is written through cfg_we, cfg_index
// and cfg_data; the user must write it only when idle, as the block itself
// does not enforce this.
`include "pll_divider_search_assert.svh"
module pll_divider_search
  import pds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [21:0] target_freq,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [6:0]  feedback_m,
  output logic [4:0]  input_n,
  output logic [1:0]  post_shift_r,
  output logic [7:0]  packed_n_r_byte,
  output logic [7:0]  packed_m_byte,
  output logic [19:0] achieved_khz,
  output logic [23:0] freq_error
);

  logic [15:0] ref_clock;
  logic [19:0] vco_min;
  logic [19:0] vco_max;
  logic [19:0] max_error;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_clock <= 16'd14318;
      vco_min <= 20'd135000;
      vco_max <= 20'd270000;
      max_error <= 20'd5000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REF_CLOCK: ref_clock <= cfg_data[15:0];
        REG_VCO_MIN:   vco_min <= cfg_data;
        REG_VCO_MAX:   vco_max <= cfg_data;
        REG_MAX_ERROR: max_error <= cfg_data;
        default: ;
      endcase
    end
  end

  pds_cmd_t  cmd;
  pds_stat_t stat;
  logic      in_take;
  logic      out_load;
  logic      out_free;

  assign out_free = !out_valid || !out_stall;

  pds_control u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_zero  (target_freq == '0),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd),
    .in_take  (in_take),
    .out_load (out_load)
  );

  pds_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .target_freq (target_freq),
    .ref_clock   (ref_clock),
    .vco_min     (vco_min),
    .vco_max     (vco_max),
    .max_error   (max_error),
    .res_status  (status),
    .res_m       (feedback_m),
    .res_n       (input_n),
    .res_r       (post_shift_r),
    .res_khz     (achieved_khz),
    .res_ppm     (freq_error)
  );

  assign in_stall = !in_take;
  assign packed_n_r_byte = {1'b0, post_shift_r, input_n};
  assign packed_m_byte = {1'b0, feedback_m};

  // Output valid: set when a result is formed, cleared on transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `PDS_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(freq_error))
  `PDS_ASSERT_IMP(a_no_overwrite, clk, rst, out_load, !(out_valid && out_stall))
  `PDS_ASSERT_IMP(a_ok_fields, clk, rst, out_valid && status != ST_OK, feedback_m == '0)

endmodule

// ===== rtl/pds_divider.sv =====
// Restoring binary divider, one quotient bit per cycle.
// Depends on pds_pkg for the operand widths.
module pds_divider
  import pds_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [PPM_NUM_W-1:0] dividend,
  input  logic [PPM_DEN_W-1:0] divisor,
  output logic                 busy,
  output logic                 done,
  output logic [PPM_NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic [PPM_NUM_W-1:0] quo;
  logic [PPM_DEN_W:0]   rem;
  logic [PPM_DEN_W-1:0] dsr;
  logic [CNT_W-1:0]     cnt;
  logic [PPM_DEN_W:0]   shifted;
  logic                 fits;

  // One shift and trial subtract per cycle.
  always_comb begin
    shifted = {rem[PPM_DEN_W-1:0], quo[PPM_NUM_W-1]};
    fits = shifted >= {1'b0, dsr};
  end

  // Iteration: load on start, then one quotient bit per cycle until the count runs out.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= !start && busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(DIV_STEPS);
        quo <= dividend;
        rem <= '0;
        dsr <= divisor;
      end else if (busy) begin
        rem <= fits ? shifted - {1'b0, dsr} : shifted;
        quo <= {quo[PPM_NUM_W-2:0], fits};
        cnt <= cnt - 1'b1;
        busy <= (cnt != CNT_W'(1));
      end
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/pds_datapath.sv =====
// Datapath of the PLL divider search: counters, candidate test, best tracking,
// final divisions and the result register. Depends on pds_pkg and pds_divider.
module pds_datapath
  import pds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  pds_cmd_t    cmd,
  output pds_stat_t   stat,
  input  logic [21:0] target_freq,
  input  logic [15:0] ref_clock,
  input  logic [19:0] vco_min,
  input  logic [19:0] vco_max,
  input  logic [19:0] max_error,
  output logic [1:0]  res_status,
  output logic [6:0]  res_m,
  output logic [4:0]  res_n,
  output logic [1:0]  res_r,
  output logic [19:0] res_khz,
  output logic [23:0] res_ppm
);

  // Search counters and the captured target.
  logic [21:0] target;
  logic [6:0]  m;
  logic [4:0]  n;
  logic [1:0]  r;

  // Best candidate so far.
  logic        found;
  logic [30:0] win_diff;
  logic [8:0]  win_den;
  logic [6:0]  best_m;
  logic [4:0]  best_n;
  logic [1:0]  best_r;

  logic [5:0]  ndiv;
  logic [8:0]  oden;
  logic [30:0] tnum;
  logic [23:0] num;
  logic [25:0] lo_lim;
  logic [25:0] hi_lim;
  logic        in_window;
  logic [30:0] diff;
  logic [39:0] lhs;
  logic [39:0] rhs;
  logic        better;

  // Candidate evaluation for the current M, N, R.
  always_comb begin
    ndiv = 6'(n) + 6'd2;
    oden = 9'(ndiv) << r;
    tnum = 31'(target) * 31'(oden);
    num = (24'(m) + 24'd2) * 24'(ref_clock);
    lo_lim = 26'(vco_min) * 26'(ndiv);
    hi_lim = 26'(vco_max) * 26'(ndiv);
    in_window = ({2'b0, num} >= lo_lim) && ({2'b0, num} <= hi_lim);
    diff = ({7'b0, num} > tnum) ? {7'b0, num} - tnum : tnum - {7'b0, num};
    lhs = 40'(diff) * 40'(win_den);
    rhs = 40'(win_diff) * 40'(oden);
    better = in_window && (!found || lhs < rhs);
  end

  logic search_last;
  logic div_busy;
  logic div_done;

  assign search_last = (r == 2'(R_MAX)) && (n == 5'(N_MAX)) && (m == 7'(M_MAX));
  assign stat = '{search_last: search_last, div_busy: div_busy, div_done: div_done};

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.load) begin
      found <= 1'b0;
    end else if (cmd.search && better) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      target <= target_freq;
      m <= 7'd1;
      n <= 5'd1;
      r <= 2'd0;
    end else if (cmd.search) begin
      if (better) begin
        win_diff <= diff;
        win_den <= oden;
        best_m <= m;
        best_n <= n;
        best_r <= r;
      end
      if (m == 7'(M_MAX)) begin
        m <= 7'd1;
        if (n == 5'(N_MAX)) begin
          n <= 5'd1;
          r <= r + 2'd1;
        end else begin
          n <= n + 5'd1;
        end
      end else begin
        m <= m + 7'd1;
      end
    end
  end

  // Division operands: error in ppm, then achieved frequency.
  logic [30:0]          denom;
  logic [50:0]          ppm_prod;
  logic [PPM_NUM_W-1:0] div_a;
  logic [PPM_DEN_W-1:0] div_b;
  logic [PPM_NUM_W-1:0] div_q;
  logic                 div_start;
  logic [23:0]          best_num;

  always_comb begin
    denom = 31'(target) * 31'(win_den);
    ppm_prod = 51'(win_diff) * 51'(PPM_SCALE);
    best_num = (24'(best_m) + 24'd2) * 24'(ref_clock);
    if (cmd.khz_start) begin
      div_a = PPM_NUM_W'(best_num) + PPM_NUM_W'(win_den[8:1]);
      div_b = PPM_DEN_W'(win_den);
    end else begin
      div_a = PPM_NUM_W'(ppm_prod) + PPM_NUM_W'(denom[30:1]);
      div_b = PPM_DEN_W'(denom);
    end
    div_start = cmd.ppm_start || cmd.khz_start;
  end

  pds_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Capture the ppm quotient when the first division ends.
  logic [PPM_NUM_W-1:0] ppm_q;
  logic                 ppm_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      ppm_phase <= 1'b0;
    end else if (cmd.ppm_start) begin
      ppm_phase <= 1'b1;
    end else if (div_done) begin
      ppm_phase <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_done && ppm_phase) begin
      ppm_q <= div_q;
    end
  end

  // Result formation: saturate both quotients and pick the status.
  logic [23:0] ppm_clip;
  logic [19:0] khz_clip;
  logic        over_limit;
  logic [1:0]  res_status_next;
  logic [6:0]  res_m_next;
  logic [4:0]  res_n_next;
  logic [1:0]  res_r_next;
  logic [19:0] res_khz_next;
  logic [23:0] res_ppm_next;

  always_comb begin
    ppm_clip = (ppm_q > PPM_NUM_W'(ERR_FIELD_MAX)) ? ERR_FIELD_MAX : ppm_q[23:0];
    khz_clip = (div_q > PPM_NUM_W'(KHZ_FIELD_MAX)) ? KHZ_FIELD_MAX : div_q[19:0];
    over_limit = ppm_q > PPM_NUM_W'(max_error);
    res_status_next = ST_OK;
    res_m_next = '0;
    res_n_next = '0;
    res_r_next = '0;
    res_khz_next = '0;
    res_ppm_next = '0;
    if (target == '0) begin
      res_status_next = ST_INVALID;
    end else if (!found) begin
      res_status_next = ST_RANGE;
      res_ppm_next = ERR_FIELD_MAX;
    end else if (over_limit) begin
      res_status_next = ST_RANGE;
      res_ppm_next = ppm_clip;
    end else begin
      res_m_next = best_m;
      res_n_next = best_n;
      res_r_next = best_r;
      res_ppm_next = ppm_clip;
      res_khz_next = khz_clip;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_status <= res_status_next;
      res_m <= res_m_next;
      res_n <= res_n_next;
      res_r <= res_r_next;
      res_khz <= res_khz_next;
      res_ppm <= res_ppm_next;
    end
  end

endmodule

// ===== rtl/pds_control.sv =====
// Controller state machine of the PLL divider search.
// Depends on pds_pkg and the assertion macro header.
`include "pll_divider_search_assert.svh"
module pds_control
  import pds_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_zero,
  input  logic      out_free,
  input  pds_stat_t stat,
  output pds_cmd_t  cmd,
  output logic      in_take,
  output logic      out_load
);

  pds_state_t state, state_next;
  logic       zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      zero <= 1'b0;
    end else begin
      state <= state_next;
      if (in_take) begin
        zero <= in_zero;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid && out_free) state_next = in_zero ? S_DONE : S_SEARCH;
      S_SEARCH: if (stat.search_last) state_next = S_PPM;
      S_PPM:    if (stat.div_done) state_next = S_KHZ;
      S_KHZ:    if (stat.div_done) state_next = S_DONE;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs. The error division starts in the first S_PPM cycle, once the
  // last candidate has been folded into the best registers.
  always_comb begin
    cmd = '0;
    in_take = 1'b0;
    out_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_take = in_valid && out_free;
        cmd.load = in_take;
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
      end
      S_PPM: begin
        cmd.ppm_start = !stat.div_busy && !stat.div_done;
        cmd.khz_start = stat.div_done;
      end
      S_KHZ: begin
        cmd.finish = stat.div_done;
        out_load = stat.div_done;
      end
      S_DONE: begin
        cmd.finish = zero;
        out_load = zero;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `PDS_ASSERT_IMP(a_take_idle, clk, rst, in_take, state == S_IDLE)
  `PDS_ASSERT_NEXT(a_search_ppm, clk, rst, state == S_SEARCH && stat.search_last, state == S_PPM)
  `PDS_ASSERT_IMP(a_load_once, clk, rst, out_load, cmd.finish)

endmodule
